/* hw/rtl/rcafm_pkg.sv */
// ----------------------------------------------------------------------------
// rcafm_pkg
// Shared codes and constants for the arming and failsafe monitor.
// ----------------------------------------------------------------------------
package rcafm_pkg;

	localparam int FUNC_W  = 3;
	localparam int MODE_W  = 3;
	localparam int VAL_W   = 11;
	localparam int IDX_W   = 4;
	localparam int CNT_W   = 16;
	localparam int CFGI_W  = 3;
	localparam int CFGD_W  = 16;
	localparam int ARMI_W  = 5;

	typedef logic [FUNC_W-1:0] func_t;
	typedef logic [MODE_W-1:0] mode_t;
	typedef logic [VAL_W-1:0]  chval_t;
	typedef logic [IDX_W-1:0]  chidx_t;
	typedef logic [CNT_W-1:0]  count_t;
	typedef logic [CFGI_W-1:0] cfg_index_t;
	typedef logic [CFGD_W-1:0] cfg_data_t;

	localparam func_t FUNC_TICK   = 3'd0;
	localparam func_t FUNC_CHAN   = 3'd1;
	localparam func_t FUNC_SENT   = 3'd2;
	localparam func_t FUNC_ARM    = 3'd3;
	localparam func_t FUNC_DISARM = 3'd4;
	localparam func_t FUNC_ESTOP  = 3'd5;

	localparam mode_t MODE_DISARMED = 3'd0;
	localparam mode_t MODE_PENDING  = 3'd1;
	localparam mode_t MODE_ARMED    = 3'd2;
	localparam mode_t MODE_FAILSAFE = 3'd3;
	localparam mode_t MODE_ESTOP    = 3'd4;

	localparam cfg_index_t CFG_ARM_CHANNEL = 3'd0;
	localparam cfg_index_t CFG_ARM_THRESH  = 3'd1;
	localparam cfg_index_t CFG_THR_FLOOR   = 3'd2;
	localparam cfg_index_t CFG_ARM_DELAY   = 3'd3;
	localparam cfg_index_t CFG_FS_TIMEOUT  = 3'd4;

	localparam chval_t CHANNEL_MID    = 11'd992;
	localparam chval_t CHANNEL_MIN    = 11'd172;
	localparam int     THROTTLE_INDEX = 2;

	localparam logic [ARMI_W-1:0] RST_ARM_CHANNEL = 5'd4;
	localparam chval_t            RST_ARM_THRESH  = 11'd1400;
	localparam chval_t            RST_THR_FLOOR   = 11'd172;
	localparam count_t            RST_ARM_DELAY   = 16'd1000;
	localparam count_t            RST_FS_TIMEOUT  = 16'd500;
	localparam count_t            COUNT_MAX       = 16'hFFFF;

	typedef struct packed {
		logic   kind;
		chidx_t index;
		chval_t value;
		logic   last;
	} result_t;

endpackage

/* hw/rtl/rcafm_ram.sv */
// ----------------------------------------------------------------------------
// rcafm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rcafm_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/rc_arming_failsafe_monitor.sv */
// ----------------------------------------------------------------------------
// rc_arming_failsafe_monitor
// Arming and failsafe monitor: collects channel words in a frame store and,
// on frame end, applies the arming rules and emits every channel.
//
// channel  handshake            payload
// in       in_valid/in_ready    func, chan_index, chan_value, frame_end
// out      out_valid/out_ready  out_kind, out_index, out_value, out_last,
//                               safety_state, armed_flag
// cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// a channel word that does not end a frame is only accepted; other events are
// accepted, then the status item is loaded into the output register
// a frame end takes one frame store read for the arm switch, then one store
// read per emitted channel on the single read port
// reset clears mode, counters and per-entry valid bits; no clearing pass
// a stalled output holds the sequencer, which re-reads the same entry
// ----------------------------------------------------------------------------
module rc_arming_failsafe_monitor #(
	parameter int NUM_CHANNELS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  rcafm_pkg::func_t       func,
	input  rcafm_pkg::chidx_t      chan_index,
	input  rcafm_pkg::chval_t      chan_value,
	input  logic                   frame_end,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   out_kind,
	output rcafm_pkg::chidx_t      out_index,
	output rcafm_pkg::chval_t      out_value,
	output logic                   out_last,
	output rcafm_pkg::mode_t       safety_state,
	output logic                   armed_flag,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  rcafm_pkg::cfg_index_t  cfg_index,
	input  rcafm_pkg::cfg_data_t   cfg_data
);

	import rcafm_pkg::*;

	localparam int  AW     = $clog2(NUM_CHANNELS);
	localparam bit  THR_OK = THROTTLE_INDEX < NUM_CHANNELS;
	localparam logic [AW-1:0] LAST_CH = AW'(NUM_CHANNELS - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_STAT = 3'd1;
	localparam logic [2:0] ST_ARM  = 3'd2;
	localparam logic [2:0] ST_RULE = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	// configuration
	logic [ARMI_W-1:0] arm_idx_q;
	chval_t            arm_thr_q;
	chval_t            thr_floor_q;
	count_t            arm_delay_q;
	count_t            fs_timeout_q;

	// control state
	logic [2:0]        state_q;
	mode_t             mode_q;
	count_t            arm_wait_q;
	count_t            frame_age_q;
	logic [NUM_CHANNELS-1:0] vld_q;
	logic [AW-1:0]     cnt_q;
	logic              fs_q;
	logic              force_thr_q;

	// output register
	logic              out_valid_q;
	result_t           res_q;
	mode_t             res_mode_q;

	// frame store access
	logic              we;
	logic [AW-1:0]     waddr;
	logic [AW-1:0]     raddr;
	chval_t            rdata;
	logic              rvld_s1;
	chval_t            stored;

	logic              accept;
	logic              out_free;
	logic              load_out;
	logic              arm_ok;
	logic              req;
	logic              emit_last;
	logic              is_thr;
	logic              is_arm;
	chval_t            emit_val;
	count_t            age_inc;
	count_t            wait_inc;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign load_out  = out_free && (state_q == ST_STAT || state_q == ST_EMIT);

	assign arm_ok = !arm_idx_q[ARMI_W-1] &&
		({1'b0, arm_idx_q[IDX_W-1:0]} < (IDX_W+1)'(NUM_CHANNELS));

	assign we    = accept && (func == FUNC_CHAN) &&
		({1'b0, chan_index} < (IDX_W+1)'(NUM_CHANNELS));
	assign waddr = chan_index[AW-1:0];

	assign stored = rvld_s1 ? rdata : '0;
	assign req    = arm_ok && (stored > arm_thr_q);

	assign emit_last = (cnt_q == LAST_CH);
	assign is_thr    = THR_OK && (32'(cnt_q) == THROTTLE_INDEX);
	assign is_arm    = arm_ok && (arm_idx_q[IDX_W-1:0] == IDX_W'(cnt_q));

	assign age_inc  = (frame_age_q == COUNT_MAX) ? COUNT_MAX : frame_age_q + 16'd1;
	assign wait_inc = (arm_wait_q == COUNT_MAX) ? COUNT_MAX : arm_wait_q + 16'd1;

	always_comb begin
		if (fs_q) begin
			if (is_arm) begin
				emit_val = CHANNEL_MIN;
			end else if (is_thr) begin
				emit_val = thr_floor_q;
			end else begin
				emit_val = CHANNEL_MID;
			end
		end else if (force_thr_q && is_thr) begin
			emit_val = thr_floor_q;
		end else begin
			emit_val = stored;
		end
	end

	always_comb begin
		unique case (state_q)
			ST_ARM:  raddr = arm_idx_q[AW-1:0];
			ST_RULE: raddr = '0;
			ST_EMIT: begin
				if (!out_free) begin
					raddr = cnt_q;
				end else if (emit_last) begin
					raddr = '0;
				end else begin
					raddr = cnt_q + AW'(1);
				end
			end
			default: raddr = '0;
		endcase
	end

	rcafm_ram #(
		.WIDTH(VAL_W),
		.DEPTH(NUM_CHANNELS)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(chan_value),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			rvld_s1 <= vld_q[raddr];
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_idx_q    <= RST_ARM_CHANNEL;
			arm_thr_q    <= RST_ARM_THRESH;
			thr_floor_q  <= RST_THR_FLOOR;
			arm_delay_q  <= RST_ARM_DELAY;
			fs_timeout_q <= RST_FS_TIMEOUT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ARM_CHANNEL: arm_idx_q    <= cfg_data[ARMI_W-1:0];
				CFG_ARM_THRESH:  arm_thr_q    <= cfg_data[VAL_W-1:0];
				CFG_THR_FLOOR:   thr_floor_q  <= cfg_data[VAL_W-1:0];
				CFG_ARM_DELAY:   arm_delay_q  <= cfg_data;
				CFG_FS_TIMEOUT:  fs_timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_DISARMED;
			arm_wait_q  <= '0;
			frame_age_q <= '0;
			cnt_q       <= '0;
			fs_q        <= 1'b0;
			force_thr_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (func == FUNC_CHAN) begin
							if (frame_end) begin
								state_q <= ST_ARM;
							end
						end else begin
							state_q <= ST_STAT;
							case (func)
								FUNC_TICK: begin
									arm_wait_q  <= wait_inc;
									frame_age_q <= age_inc;
									if (mode_q != MODE_ESTOP && mode_q != MODE_FAILSAFE &&
										age_inc >= fs_timeout_q) begin
										mode_q <= MODE_FAILSAFE;
									end
								end
								FUNC_SENT: begin
									frame_age_q <= '0;
									if (mode_q == MODE_FAILSAFE) begin
										mode_q <= MODE_DISARMED;
									end
								end
								FUNC_ARM: begin
									if (mode_q == MODE_DISARMED) begin
										mode_q     <= MODE_PENDING;
										arm_wait_q <= '0;
									end
								end
								FUNC_DISARM: begin
									if (mode_q == MODE_ARMED || mode_q == MODE_PENDING) begin
										mode_q <= MODE_DISARMED;
									end
								end
								FUNC_ESTOP: mode_q <= MODE_ESTOP;
								default: ;
							endcase
						end
					end
				end
				ST_STAT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_ARM: begin
					state_q <= ST_RULE;
				end
				ST_RULE: begin
					cnt_q   <= '0;
					state_q <= ST_EMIT;
					if (mode_q == MODE_ESTOP || mode_q == MODE_FAILSAFE) begin
						fs_q        <= 1'b1;
						force_thr_q <= 1'b0;
					end else begin
						fs_q        <= 1'b0;
						force_thr_q <= (mode_q != MODE_ARMED) || !req;
						if (mode_q == MODE_DISARMED) begin
							if (req) begin
								mode_q     <= MODE_PENDING;
								arm_wait_q <= '0;
							end
						end else if (mode_q == MODE_PENDING) begin
							if (!req) begin
								mode_q <= MODE_DISARMED;
							end else if (arm_wait_q >= arm_delay_q) begin
								mode_q <= MODE_ARMED;
							end
						end else if (!req) begin
							mode_q <= MODE_DISARMED;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (emit_last) begin
							state_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q + AW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_STAT && out_free) begin
			res_q.kind  <= 1'b0;
			res_q.index <= '0;
			res_q.value <= '0;
			res_q.last  <= 1'b1;
			res_mode_q  <= mode_q;
		end else if (state_q == ST_EMIT && out_free) begin
			res_q.kind  <= 1'b1;
			res_q.index <= IDX_W'(cnt_q);
			res_q.value <= emit_val;
			res_q.last  <= emit_last;
			res_mode_q  <= mode_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_kind     = res_q.kind;
	assign out_index    = res_q.index;
	assign out_value    = res_q.value;
	assign out_last     = res_q.last;
	assign safety_state = res_mode_q;
	assign armed_flag   = (res_mode_q == MODE_ARMED);

	// emergency stop is only left through reset
	a_estop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_ESTOP |=> mode_q == MODE_ESTOP)
		else $error("emergency stop left without reset");

	// a status item always closes its input
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_kind |-> out_last)
		else $error("status item without last mark");

	// the channel sequencer never runs past the frame
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> 32'(cnt_q) < NUM_CHANNELS)
		else $error("channel counter out of range");

	// the last channel item hands control back to idle
	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && out_free && emit_last |=> state_q == ST_IDLE)
		else $error("sequencer did not return to idle");

endmodule
